FILE: rtl/first_fit_page_range_allocator_core_defines.svh
// assertion macros for the allocator rtl
`ifndef FIRST_FIT_PAGE_RANGE_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_PAGE_RANGE_ALLOCATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// condition holds at every edge outside reset
`define FFPRA_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: cond");

// consequence holds in the same cycle as the antecedent
`define FFPRA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante implies cons");

// consequence holds in the cycle after the antecedent
`define FFPRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante then cons");

`else

`define FFPRA_ASSERT_ALWAYS(label, clk, rst, cond)
`define FFPRA_ASSERT_IMP(label, clk, rst, ante, cons)
`define FFPRA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/ffpra_pkg.sv
package ffpra_pkg;

   localparam int MAX_RANGES = 16;
   localparam int PAGE_BITS  = 20;
   localparam int LEN_BITS   = PAGE_BITS + 1;
   localparam int COUNT_BITS = $clog2(MAX_RANGES + 1);

   typedef enum logic [0:0] {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_FIT     = 2'd1,
      STATUS_TABLE_FULL = 2'd2
   } status_type;

   typedef struct packed {
      command_type          command;
      logic [PAGE_BITS-1:0] page_start;
      logic [LEN_BITS-1:0]  page_count;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [PAGE_BITS-1:0] range_start;
      logic [LEN_BITS-1:0]  range_count;
   } rsp_type;

   // one free range held by a cell
   typedef struct packed {
      logic [PAGE_BITS-1:0] start;
      logic [LEN_BITS-1:0]  length;
   } entry_type;

   // what the cells do in the update cycle
   typedef enum logic [2:0] {
      MODE_HOLD,
      MODE_ALLOC,
      MODE_MERGE3,
      MODE_GROW_PREV,
      MODE_GROW_NEXT,
      MODE_INSERT
   } mode_type;

   // control broadcast to every cell
   typedef struct packed {
      logic                 eval;
      logic                 apply;
      mode_type             mode;
      logic [PAGE_BITS-1:0] start;
      logic [LEN_BITS-1:0]  count;
   } bcast_type;

   // per cell compare results, registered in the evaluate cycle
   typedef struct packed {
      logic valid;
      logic first_fit;
      logic exact;
      logic is_pos;
      logic is_prev;
      logic end_touch;
      logic next_touch;
   } flags_type;

   // clamp a joined length at the all-ones length
   function automatic logic [LEN_BITS-1:0] sat_len(input logic [LEN_BITS+1:0] v);
      logic [LEN_BITS-1:0] r;
      if (v[LEN_BITS+1:LEN_BITS] != 2'b00) begin
         r = '1;
      end else begin
         r = v[LEN_BITS-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/ffpra_cell.sv
module ffpra_cell import ffpra_pkg::*; (
   input  logic                 clock,
   input  bcast_type            bcast,
   input  logic                 entry_valid,
   input  entry_type            left_entry,
   input  entry_type            right_entry,
   input  logic                 le_chain_in,
   output logic                 le_chain_out,
   input  logic                 fit_chain_in,
   output logic                 fit_chain_out,
   input  logic                 pos_right_in,
   output logic                 pos_out,
   input  logic                 shift_chain_in,
   output logic                 shift_chain_out,
   output entry_type            entry_out,
   output flags_type            flags_out,
   output logic [PAGE_BITS-1:0] fit_start_out
);

   entry_type           entry_ff, entry_in;
   flags_type           flags_ff, flags_in;
   logic                le_own, fit_own, trigger;
   logic [LEN_BITS:0]   end_sum, next_sum;
   logic [LEN_BITS+1:0] grow_sum, merge_sum;

   // evaluate: compares against the request, chains ripple along the row
   always_comb begin
      le_own        = entry_valid && (entry_ff.start <= bcast.start);
      pos_out       = le_chain_in && !le_own;
      le_chain_out  = le_chain_in && le_own;
      fit_own       = entry_valid && (entry_ff.length >= bcast.count);
      fit_chain_out = fit_chain_in || fit_own;
      end_sum  = {2'b00, entry_ff.start} + {1'b0, entry_ff.length};
      next_sum = {2'b00, bcast.start} + {1'b0, bcast.count};

      flags_in.valid      = entry_valid;
      flags_in.first_fit  = fit_own && !fit_chain_in;
      flags_in.exact      = (entry_ff.length == bcast.count);
      flags_in.is_pos     = pos_out;
      flags_in.is_prev    = le_chain_out && pos_right_in;
      flags_in.end_touch  = (end_sum == {2'b00, bcast.start});
      flags_in.next_touch = (next_sum == {2'b00, entry_ff.start});
   end

   // update: shrink, grow, load or shift from a neighbor
   always_comb begin
      case (bcast.mode)
         MODE_ALLOC:  trigger = flags_ff.first_fit && flags_ff.exact;
         MODE_MERGE3: trigger = flags_ff.is_pos;
         MODE_INSERT: trigger = flags_ff.is_pos;
         default:     trigger = 1'b0;
      endcase
      shift_chain_out = shift_chain_in || trigger;

      grow_sum  = {2'b00, entry_ff.length} + {2'b00, bcast.count};
      merge_sum = grow_sum + {2'b00, right_entry.length};

      entry_in = entry_ff;
      if (bcast.apply) begin
         case (bcast.mode)
            MODE_ALLOC: begin
               if (shift_chain_out) begin
                  entry_in = right_entry;
               end else if (flags_ff.first_fit) begin
                  entry_in.start  = entry_ff.start + bcast.count[PAGE_BITS-1:0];
                  entry_in.length = entry_ff.length - bcast.count;
               end
            end
            MODE_MERGE3: begin
               if (shift_chain_out) begin
                  entry_in = right_entry;
               end else if (flags_ff.is_prev) begin
                  entry_in.length = sat_len(merge_sum);
               end
            end
            MODE_GROW_PREV: begin
               if (flags_ff.is_prev) begin
                  entry_in.length = sat_len(grow_sum);
               end
            end
            MODE_GROW_NEXT: begin
               if (flags_ff.is_pos) begin
                  entry_in.start  = bcast.start;
                  entry_in.length = sat_len(grow_sum);
               end
            end
            MODE_INSERT: begin
               if (shift_chain_in) begin
                  entry_in = left_entry;
               end else if (flags_ff.is_pos) begin
                  entry_in.start  = bcast.start;
                  entry_in.length = bcast.count;
               end
            end
            default: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (bcast.eval) begin
         flags_ff <= flags_in;
      end
   end

   assign entry_out     = entry_ff;
   assign flags_out     = flags_ff;
   assign fit_start_out = flags_ff.first_fit ? entry_ff.start : '0;

endmodule

FILE: rtl/first_fit_page_range_allocator_core.sv
// first-fit page range allocator with a sorted, coalescing free table.
// the table is a row of MAX_RANGES cells, each holding one free range, kept
// sorted by start page; used_ff says how many cells are live. an
// allocate beat takes the lowest range long enough, returns its first pages
// and shrinks it from the front (a range that empties is closed up). a free
// beat slots the range into sorted place, joining a touching neighbor on
// either side; a free that joins nothing into a full table answers
// table_full. the table is empty after reset; load memory with free beats.
// each command passes accept, evaluate (every cell compares against
// the request while the first-fit and insert-position chains ripple along
// the row) and update (cells shrink, grow, load or shift to a neighbor in
// one step). a new request is taken in the cycle after the update, so no
// command is accepted while another is in flight; the update stalls while
// a previous response still sits unread in the output register.
`include "first_fit_page_range_allocator_core_defines.svh"

module first_fit_page_range_allocator_core import ffpra_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_UPDATE
   } state_type;

   state_type             state_ff, state_in;
   logic [COUNT_BITS-1:0] used_ff, used_in;
   req_type               cmd_ff, cmd_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // row wiring
   bcast_type            bcast;
   entry_type            entries [MAX_RANGES];
   flags_type            flags [MAX_RANGES];
   logic [PAGE_BITS-1:0] fit_starts [MAX_RANGES];
   logic [MAX_RANGES:0]  le_chain, fit_chain, shift_chain, pos_chain;

   // summaries of the registered cell flags
   logic [MAX_RANGES-1:0] first_fit_vec, pos_vec;
   logic                  any_fit, fit_exact, join_prev, join_next, table_full;
   logic [PAGE_BITS-1:0]  fit_start_any;
   logic                  slot_free, apply;
   mode_type              mode;
   rsp_type               result;
   logic [COUNT_BITS-1:0] used_after;

   assign le_chain[0]             = 1'b1;
   assign fit_chain[0]            = 1'b0;
   assign shift_chain[0]          = 1'b0;
   // past the last cell counts as the insert position
   assign pos_chain[MAX_RANGES]   = 1'b1;

   for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
      entry_type left_e, right_e;
      logic      live;

      assign live = COUNT_BITS'(i) < used_ff;

      if (i == 0) begin : g_first
         assign left_e = '0;
      end else begin : g_mid_left
         assign left_e = entries[i-1];
      end

      if (i == MAX_RANGES - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_mid_right
         assign right_e = entries[i+1];
      end

      ffpra_cell u_cell (
         .clock           (clock),
         .bcast           (bcast),
         .entry_valid     (live),
         .left_entry      (left_e),
         .right_entry     (right_e),
         .le_chain_in     (le_chain[i]),
         .le_chain_out    (le_chain[i+1]),
         .fit_chain_in    (fit_chain[i]),
         .fit_chain_out   (fit_chain[i+1]),
         .pos_right_in    (pos_chain[i+1]),
         .pos_out         (pos_chain[i]),
         .shift_chain_in  (shift_chain[i]),
         .shift_chain_out (shift_chain[i+1]),
         .entry_out       (entries[i]),
         .flags_out       (flags[i]),
         .fit_start_out   (fit_starts[i])
      );
   end

   // or-reduce the per-cell flags for the command decision
   always_comb begin
      any_fit       = 1'b0;
      fit_exact     = 1'b0;
      join_prev     = 1'b0;
      join_next     = 1'b0;
      fit_start_any = '0;
      for (int i = 0; i < MAX_RANGES; i++) begin
         first_fit_vec[i] = flags[i].first_fit;
         pos_vec[i]       = flags[i].is_pos;
         any_fit          = any_fit | flags[i].first_fit;
         fit_exact        = fit_exact | (flags[i].first_fit & flags[i].exact);
         join_prev        = join_prev | (flags[i].is_prev & flags[i].end_touch);
         join_next        = join_next |
                            (flags[i].is_pos & flags[i].valid & flags[i].next_touch);
         fit_start_any    = fit_start_any | fit_starts[i];
      end
   end

   assign table_full = (used_ff == COUNT_BITS'(MAX_RANGES));

   // pick the row operation and the response for the current command
   always_comb begin
      mode               = MODE_HOLD;
      result.status      = STATUS_OK;
      result.range_start = '0;
      result.range_count = '0;
      used_after         = used_ff;
      if (cmd_ff.command == CMD_ALLOC) begin
         if (any_fit) begin
            mode               = MODE_ALLOC;
            result.range_start = fit_start_any;
            result.range_count = cmd_ff.page_count;
            if (fit_exact) begin
               used_after = used_ff - COUNT_BITS'(1);
            end
         end else begin
            result.status = STATUS_NO_FIT;
         end
      end else if (cmd_ff.page_count != '0) begin
         if (join_prev && join_next) begin
            mode       = MODE_MERGE3;
            used_after = used_ff - COUNT_BITS'(1);
         end else if (join_prev) begin
            mode = MODE_GROW_PREV;
         end else if (join_next) begin
            mode = MODE_GROW_NEXT;
         end else if (table_full) begin
            result.status = STATUS_TABLE_FULL;
         end else begin
            mode       = MODE_INSERT;
            used_after = used_ff + COUNT_BITS'(1);
         end
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign apply     = (state_ff == ST_UPDATE) && slot_free;

   assign bcast.eval  = (state_ff == ST_EVAL);
   assign bcast.apply = apply;
   assign bcast.mode  = mode;
   assign bcast.start = cmd_ff.page_start;
   assign bcast.count = cmd_ff.page_count;

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      cmd_in       = cmd_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (slot_free) begin
               used_in      = used_after;
               rsp_data_in  = result;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // table never holds more ranges than cells
   `FFPRA_ASSERT_ALWAYS(a_used_bound, clock, reset, used_ff <= COUNT_BITS'(MAX_RANGES))
   // at most one first-fit cell and one insert position in the row
   `FFPRA_ASSERT_IMP(a_one_fit, clock, reset, state_ff == ST_UPDATE, $onehot0(first_fit_vec))
   `FFPRA_ASSERT_IMP(a_one_pos, clock, reset, state_ff == ST_UPDATE, $onehot0(pos_vec))
   // table_full only goes out while every cell is live
   `FFPRA_ASSERT_IMP(a_full_status, clock, reset, rsp_valid_ff && rsp_data_ff.status == STATUS_TABLE_FULL, used_ff == COUNT_BITS'(MAX_RANGES))
   // an insert adds exactly one live cell
   `FFPRA_ASSERT_NEXT(a_insert_grows, clock, reset, apply && mode == MODE_INSERT, used_ff == $past(used_ff) + COUNT_BITS'(1))

endmodule

FILE: sim/first_fit_page_range_allocator_core_tb.sv
module first_fit_page_range_allocator_core_tb;
   import ffpra_pkg::*;

   localparam logic [LEN_BITS-1:0]   LEN_MAX   = '1;
   localparam logic [LEN_BITS+1:0]   LEN_LIMIT = {2'b00, LEN_MAX};
   localparam int                    IDLE_PCT  = 38;

   // one queued request plus a flag that holds it back until the block is drained
   typedef struct packed {
      logic    drain;
      req_type beat;
   } queued_beat_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   queued_beat_type pending_beats[$];
   rsp_type         expected_rsps[$];

   // free table as the block should hold it
   logic [PAGE_BITS-1:0] free_base[MAX_RANGES];
   logic [LEN_BITS-1:0]  free_len[MAX_RANGES];
   int                   free_used = 0;

   int   cycle_count    = 0;
   int   beats_accepted = 0;
   int   rsps_seen      = 0;
   int   fail_count     = 0;
   int   total_beats    = 0;
   int   hold_left      = 0;
   logic hold_done      = 1'b0;
   logic req_taken      = 1'b0;
   logic drain_next     = 1'b0;

   first_fit_page_range_allocator_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [LEN_BITS-1:0] clamp_len(logic [LEN_BITS+1:0] v);
      return (v > LEN_LIMIT) ? LEN_MAX : v[LEN_BITS-1:0];
   endfunction

   // close the gap left by entry k
   function automatic void close_range(int k);
      int j;
      for (j = k; j + 1 < free_used; j++) begin
         free_base[j] = free_base[j+1];
         free_len[j]  = free_len[j+1];
      end
      free_used--;
   endfunction

   function automatic rsp_type allocate_first_fit(logic [LEN_BITS-1:0] count);
      rsp_type r;
      int      k;
      logic    found;
      r.status      = STATUS_NO_FIT;
      r.range_start = '0;
      r.range_count = '0;
      found         = 1'b0;
      for (k = 0; k < free_used && !found; k++) begin
         if (free_len[k] >= count) begin
            found         = 1'b1;
            r.status      = STATUS_OK;
            r.range_start = free_base[k];
            r.range_count = count;
            // start wraps at the top page
            free_base[k]  = free_base[k] + count[PAGE_BITS-1:0];
            free_len[k]   = free_len[k] - count;
            if (free_len[k] == '0) close_range(k);
         end
      end
      return r;
   endfunction

   function automatic status_type release_range(logic [PAGE_BITS-1:0] start,
                                                logic [LEN_BITS-1:0]  count);
      int                  pos;
      int                  j;
      logic                touch_prev;
      logic                touch_next;
      logic [LEN_BITS+1:0] sum;
      if (count == '0) return STATUS_OK;
      pos = 0;
      // equal starts go after the existing range
      while (pos < free_used && free_base[pos] <= start) pos++;
      touch_prev = 1'b0;
      touch_next = 1'b0;
      // touch tests use exact sums, no wrap
      if (pos > 0)
         touch_prev = ({3'b000, free_base[pos-1]} + {2'b00, free_len[pos-1]})
                      == {3'b000, start};
      if (pos < free_used)
         touch_next = ({3'b000, start} + {2'b00, count}) == {3'b000, free_base[pos]};
      if (touch_prev && touch_next) begin
         sum = {2'b00, free_len[pos-1]} + {2'b00, count} + {2'b00, free_len[pos]};
         free_len[pos-1] = clamp_len(sum);
         close_range(pos);
      end else if (touch_prev) begin
         sum = {2'b00, free_len[pos-1]} + {2'b00, count};
         free_len[pos-1] = clamp_len(sum);
      end else if (touch_next) begin
         sum = {2'b00, free_len[pos]} + {2'b00, count};
         free_base[pos] = start;
         free_len[pos]  = clamp_len(sum);
      end else begin
         if (free_used >= MAX_RANGES) return STATUS_TABLE_FULL;
         for (j = free_used; j > pos; j--) begin
            free_base[j] = free_base[j-1];
            free_len[j]  = free_len[j-1];
         end
         free_base[pos] = start;
         free_len[pos]  = count;
         free_used++;
      end
      return STATUS_OK;
   endfunction

   function automatic rsp_type predict_rsp(req_type beat);
      rsp_type r;
      r.status      = STATUS_OK;
      r.range_start = '0;
      r.range_count = '0;
      if (beat.command == CMD_ALLOC) r = allocate_first_fit(beat.page_count);
      else r.status = release_range(beat.page_start, beat.page_count);
      return r;
   endfunction

   // ---------------------------------------------------------------- helpers

   function automatic void queue_item(command_type cmd, logic [PAGE_BITS-1:0] start,
                                      logic [LEN_BITS-1:0] count);
      queued_beat_type q;
      q.drain           = drain_next;
      q.beat.command    = cmd;
      q.beat.page_start = start;
      q.beat.page_count = count;
      pending_beats.insert(pending_beats.size(), q);
      drain_next = 1'b0;
   endfunction

   // random idling, switched off for a stretch in the middle of the run
   function automatic logic roll_idle();
      if (cycle_count >= 1500 && cycle_count < 3500) return 1'b0;
      return $urandom_range(99) < IDLE_PCT;
   endfunction

   task automatic log_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%0t: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_beats.size() != 0 && !roll_idle() &&
             !(pending_beats[0].drain && expected_rsps.size() != 0)) begin
            req_data  <= pending_beats[0].beat;
            req_valid <= 1'b1;
            void'(pending_beats.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(negedge clock) begin
      // one long hold-off so the block backs up into its input
      if (!hold_done && beats_accepted >= 150) begin
         hold_done = 1'b1;
         hold_left = 400;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !roll_idle();
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      req_taken   <= !reset && req_valid && req_ready;
      if (!reset) begin
         // check the result before predicting a new beat
         if (rsp_valid && rsp_ready) begin
            rsps_seen <= rsps_seen + 1;
            if (expected_rsps.size() == 0) begin
               log_failure($sformatf("unexpected beat: status %0d start %0h count %0h",
                                     rsp_data.status, rsp_data.range_start,
                                     rsp_data.range_count));
            end else begin
               want = expected_rsps.pop_front();
               if (want.status !== rsp_data.status ||
                   want.range_start !== rsp_data.range_start ||
                   want.range_count !== rsp_data.range_count)
                  log_failure($sformatf(
                     "mismatch: expected status %0d start %0h count %0h, got %0d %0h %0h",
                     want.status, want.range_start, want.range_count,
                     rsp_data.status, rsp_data.range_start, rsp_data.range_count));
            end
         end
         if (req_valid && req_ready) begin
            expected_rsps.insert(expected_rsps.size(), predict_rsp(req_data));
            beats_accepted <= beats_accepted + 1;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      int                   made;
      int                   kind;
      int                   n;
      int                   k;
      int                   j;
      int                   t;
      logic                 broken;
      logic                 mid_drain_done;
      logic [31:0]          rnd;
      logic [31:0]          rnd2;
      logic [PAGE_BITS-1:0] base;
      logic [PAGE_BITS-1:0] tmp_s;
      logic [LEN_BITS-1:0]  tmp_l;
      logic [PAGE_BITS-1:0] piece_start[8];
      logic [LEN_BITS-1:0]  piece_len[8];

      // empty table: allocate misses, zero pages too; zero-page free is ignored
      queue_item(CMD_ALLOC, 20'd0, 21'd5);
      queue_item(CMD_ALLOC, 20'hFFFFF, 21'd0);
      queue_item(CMD_FREE, 20'd100, 21'd0);
      // join with the preceding range, saturating the length
      queue_item(CMD_FREE, 20'h00000, 21'h080000);
      queue_item(CMD_FREE, 20'h80000, 21'h1FFFFF);
      queue_item(CMD_ALLOC, 20'h00000, 21'h1FFFFF);
      // range at the top page, then join with the following range
      queue_item(CMD_FREE, 20'hFFFFF, 21'h100000);
      queue_item(CMD_FREE, 20'h00000, 21'h0FFFFF);
      // start wraps past the top page
      queue_item(CMD_ALLOC, 20'h00000, 21'h1FFFFE);
      queue_item(CMD_ALLOC, 20'h00000, 21'd1);
      // join both sides, append after the last range
      queue_item(CMD_FREE, 20'd0, 21'd16);
      queue_item(CMD_FREE, 20'd32, 21'd16);
      queue_item(CMD_FREE, 20'd16, 21'd16);
      queue_item(CMD_FREE, 20'd48, 21'd8);
      queue_item(CMD_FREE, 20'd200, 21'd10);
      queue_item(CMD_FREE, 20'd190, 21'd10);
      // equal start, overlapping
      queue_item(CMD_FREE, 20'd190, 21'd4);
      // zero-page allocate on a live table, then an exact fit that empties a range
      queue_item(CMD_ALLOC, 20'd0, 21'd0);
      queue_item(CMD_ALLOC, 20'd0, 21'd56);
      queue_item(CMD_ALLOC, 20'd0, 21'd100);

      // random part: mostly tiled frees and allocates, some full-table bursts and noise
      drain_next     = 1'b1;
      mid_drain_done = 1'b0;
      made           = 0;
      while (made < 700) begin
         if (!mid_drain_done && made >= 350) begin
            drain_next     = 1'b1;
            mid_drain_done = 1'b1;
         end
         kind = $urandom_range(99);
         if (kind < 50) begin
            // adjacent pieces freed in random order, sometimes with gaps or overlaps
            broken = kind >= 35;
            n   = $urandom_range(2, 6);
            rnd = $urandom;
            base = (rnd[31:30] == 2'b00) ? {10'd0, rnd[9:0]} : rnd[PAGE_BITS-1:0];
            for (k = 0; k < n; k++) begin
               rnd            = $urandom_range(1, 32);
               piece_start[k] = base;
               piece_len[k]   = rnd[LEN_BITS-1:0];
               base           = base + rnd[PAGE_BITS-1:0];
               if (broken) begin
                  t = $urandom_range(2);
                  if (t == 0) base = base - 20'd1;
                  else if (t == 2) base = base + 20'd1;
               end
            end
            for (k = n - 1; k > 0; k--) begin
               j              = $urandom_range(k);
               tmp_s          = piece_start[k];
               tmp_l          = piece_len[k];
               piece_start[k] = piece_start[j];
               piece_len[k]   = piece_len[j];
               piece_start[j] = tmp_s;
               piece_len[j]   = tmp_l;
            end
            for (k = 0; k < n; k++) queue_item(CMD_FREE, piece_start[k], piece_len[k]);
            made += n;
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++) begin
               rnd  = $urandom;
               rnd2 = $urandom_range(0, 48);
               queue_item(CMD_ALLOC, rnd[PAGE_BITS-1:0], rnd2[LEN_BITS-1:0]);
            end
            made += n;
         end else if (kind < 75) begin
            // allocate burst, now and then a huge request
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) begin
               rnd = $urandom;
               if ($urandom_range(9) == 0) rnd2 = $urandom;
               else rnd2 = $urandom_range(0, 40);
               queue_item(CMD_ALLOC, rnd[PAGE_BITS-1:0], rnd2[LEN_BITS-1:0]);
            end
            made += n;
         end else if (kind < 85) begin
            // spaced frees overflow the table, then small allocates drain it
            rnd  = $urandom;
            base = rnd[PAGE_BITS-1:0];
            for (k = 0; k < 20; k++) begin
               rnd2 = $urandom_range(1, 4);
               queue_item(CMD_FREE, base, rnd2[LEN_BITS-1:0]);
               base = base + 20'd8;
            end
            for (k = 0; k < 20; k++) begin
               rnd  = $urandom;
               rnd2 = $urandom_range(1, 4);
               queue_item(CMD_ALLOC, rnd[PAGE_BITS-1:0], rnd2[LEN_BITS-1:0]);
            end
            made += 40;
         end else begin
            // raw noise over the full field ranges
            rnd  = $urandom;
            rnd2 = $urandom;
            queue_item(rnd[31] ? CMD_FREE : CMD_ALLOC, rnd[PAGE_BITS-1:0],
                       rnd2[LEN_BITS-1:0]);
            made++;
         end
      end
      total_beats = pending_beats.size();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock); while (rsps_seen < total_beats);
      // let any stray beat show up
      repeat (20) @(negedge clock);
      if (expected_rsps.size() != 0)
         log_failure($sformatf("%0d results never arrived", expected_rsps.size()));
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
